[rtl/twop_pkg.sv]
`default_nettype none
package twop_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 24;
	localparam int AXIS_BITS = WORD_BITS - 1;
	// serial unit width: holds (2^2F + alpha^2) * emittance
	localparam int UNIT_BITS = 2 * ((3 * WORD_BITS + 1) / 2);

	localparam logic [1:0] OP_MUL  = 2'd0;
	localparam logic [1:0] OP_DIV  = 2'd1;
	localparam logic [1:0] OP_SQRT = 2'd2;

	typedef struct packed {
		logic       start;
		logic [1:0] op;
	} unit_req_t;

	typedef struct packed {
		logic                        opcode;
		logic signed [WORD_BITS-1:0] x_m11;
		logic signed [WORD_BITS-1:0] x_m12;
		logic signed [WORD_BITS-1:0] x_m21;
		logic signed [WORD_BITS-1:0] x_m22;
		logic signed [WORD_BITS-1:0] y_m11;
		logic signed [WORD_BITS-1:0] y_m12;
		logic signed [WORD_BITS-1:0] y_m21;
		logic signed [WORD_BITS-1:0] y_m22;
	} in_item_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] alpha_x;
		logic signed [WORD_BITS-1:0] beta_x;
		logic signed [WORD_BITS-1:0] alpha_y;
		logic signed [WORD_BITS-1:0] beta_y;
		logic        [AXIS_BITS-1:0] x_axis_major;
		logic        [AXIS_BITS-1:0] x_axis_minor;
		logic        [AXIS_BITS-1:0] y_axis_major;
		logic        [AXIS_BITS-1:0] y_axis_minor;
		logic                        x_unstable;
		logic                        y_unstable;
	} out_item_t;

endpackage
`default_nettype wire

[rtl/twop_serial.sv]
`default_nettype none
module twop_serial (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire twop_pkg::unit_req_t           req,
	input  wire logic [twop_pkg::UNIT_BITS-1:0] x,
	input  wire logic [twop_pkg::UNIT_BITS-1:0] y,
	output logic                               done,
	output logic [twop_pkg::UNIT_BITS-1:0]     res
);
	localparam int UW = twop_pkg::UNIT_BITS;
	localparam int W  = twop_pkg::WORD_BITS;
	localparam int CW = $clog2(UW + 1);

	logic [1:0]    op_q;
	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [UW-1:0] aux_q;
	logic [UW-1:0] dvs_q;
	logic [UW-1:0] rem_q;
	logic [UW-1:0] acc_q;

	logic [UW-1:0] mul_sum;
	logic [UW-1:0] div_r2;
	logic          div_ge;
	logic [UW-1:0] sq_r2;
	logic [UW-1:0] sq_tr;
	logic          sq_ge;

	// one multiplier bit, one quotient bit or one root bit per cycle
	always_comb begin
		mul_sum = {acc_q[UW-2:0], 1'b0} + (aux_q[UW-1] ? dvs_q : '0);
		div_r2  = {rem_q[UW-2:0], aux_q[UW-1]};
		div_ge  = div_r2 >= dvs_q;
		sq_r2   = {rem_q[UW-3:0], aux_q[UW-1:UW-2]};
		sq_tr   = {acc_q[UW-3:0], 2'b01};
		sq_ge   = sq_r2 >= sq_tr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			op_q   <= twop_pkg::OP_MUL;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				case (req.op)
					twop_pkg::OP_MUL: cnt_q <= CW'(W);
					twop_pkg::OP_DIV: cnt_q <= CW'(UW);
					default:          cnt_q <= CW'(UW / 2);
				endcase
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			rem_q <= '0;
			if (req.op == twop_pkg::OP_MUL) begin
				aux_q <= y << (UW - W);
				dvs_q <= x;
			end else begin
				aux_q <= x;
				dvs_q <= y;
			end
		end else if (busy_q) begin
			case (op_q)
				twop_pkg::OP_MUL: begin
					acc_q <= mul_sum;
					aux_q <= aux_q << 1;
				end
				twop_pkg::OP_DIV: begin
					acc_q <= {acc_q[UW-2:0], div_ge};
					rem_q <= div_ge ? div_r2 - dvs_q : div_r2;
					aux_q <= aux_q << 1;
				end
				default: begin
					acc_q <= {acc_q[UW-2:0], sq_ge};
					rem_q <= sq_ge ? sq_r2 - sq_tr : sq_r2;
					aux_q <= aux_q << 2;
				end
			endcase
		end
	end

	assign done = done_q;
	assign res  = acc_q;
endmodule
`default_nettype wire

[rtl/twiss_optics_propagator.sv]
`default_nettype none
// channel  | signals                  | direction | content
// ---------+--------------------------+-----------+--------------------------------
// in       | in_valid/in_ready        | request   | opcode and both 2x2 matrices
// out      | out_valid/out_ready      | result    | alpha, beta, axes, unstable flags
// cfg      | cfg_we/cfg_wdata         | write     | emittance, unsigned Q7.24
//
// one item at a time through a shared bit-serial multiply/divide/sqrt unit
// a propagate takes 32 multiplies plus one write step per entry of the products
// and the new map, then each plane runs 4 multiplies, 3 divides and 3 roots
// a load skips the products; an unstable plane ends its sequence early
// reset sets the map to identity and emittance to 1.0
// a finished result waits in the output register while the next request runs
module twiss_optics_propagator (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire twop_pkg::in_item_t            in_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output twop_pkg::out_item_t                out_data,
	input  wire logic                          cfg_we,
	input  wire logic [twop_pkg::AXIS_BITS-1:0] cfg_wdata
);
	localparam int W   = twop_pkg::WORD_BITS;
	localparam int F   = twop_pkg::FRAC_BITS;
	localparam int AXW = twop_pkg::AXIS_BITS;
	localparam int UW  = twop_pkg::UNIT_BITS;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_PM_GO = 3'd1;
	localparam logic [2:0] ST_PM_WT = 3'd2;
	localparam logic [2:0] ST_PM_WR = 3'd3;
	localparam logic [2:0] ST_TW_GO = 3'd4;
	localparam logic [2:0] ST_TW_WT = 3'd5;
	localparam logic [2:0] ST_TW_WR = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	localparam logic [3:0] SRC_F0 = 4'd0;
	localparam logic [3:0] SRC_F1 = 4'd1;
	localparam logic [3:0] SRC_F2 = 4'd2;
	localparam logic [3:0] SRC_F3 = 4'd3;
	localparam logic [3:0] SRC_G0 = 4'd4;
	localparam logic [3:0] SRC_G1 = 4'd5;
	localparam logic [3:0] SRC_G2 = 4'd6;
	localparam logic [3:0] SRC_G3 = 4'd7;
	localparam logic [3:0] SRC_P0 = 4'd8;
	localparam logic [3:0] SRC_P1 = 4'd9;
	localparam logic [3:0] SRC_P2 = 4'd10;
	localparam logic [3:0] SRC_P3 = 4'd11;

	localparam logic signed [2*W:0] ACC_MAX = {{(W+2){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [2*W:0] ACC_MIN = {{(W+2){1'b1}}, {(W-1){1'b0}}};
	localparam logic signed [W:0]   T_LIM   = $signed((W+1)'(1) << (F + 1));
	localparam logic signed [W:0]   T_NLIM  = -T_LIM;
	localparam logic [UW-1:0] U_WMAX  = {{(UW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic [UW-1:0] U_WHALF = UW'(1) << (W - 1);
	localparam logic [UW-1:0] U_AXMAX = {{(UW-AXW){1'b0}}, {AXW{1'b1}}};
	localparam logic [UW-1:0] U_FOUR  = UW'(1) << (2 * F + 2);
	localparam logic [UW-1:0] U_ONE2  = UW'(1) << (2 * F);
	localparam logic [W-1:0]  W_MAX   = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]  W_MIN   = {1'b1, {(W-1){1'b0}}};

	// operand sources of the two products of each dot step
	function automatic logic [3:0] dot_src(input logic [2:0] d, input logic t, input logic sy);
		logic [3:0] s;
		s = SRC_F0;
		case ({d, t})
			4'b0000: s = sy ? SRC_G0 : SRC_F0;
			4'b0001: s = sy ? SRC_G2 : SRC_F1;
			4'b0010: s = sy ? SRC_G1 : SRC_F0;
			4'b0011: s = sy ? SRC_G3 : SRC_F1;
			4'b0100: s = sy ? SRC_G0 : SRC_F2;
			4'b0101: s = sy ? SRC_G2 : SRC_F3;
			4'b0110: s = sy ? SRC_G1 : SRC_F2;
			4'b0111: s = sy ? SRC_G3 : SRC_F3;
			4'b1000: s = sy ? SRC_F3 : SRC_P0;
			4'b1001: s = sy ? SRC_F2 : SRC_P1;
			4'b1010: s = sy ? SRC_F0 : SRC_P1;
			4'b1011: s = sy ? SRC_F1 : SRC_P0;
			4'b1100: s = sy ? SRC_F3 : SRC_P2;
			4'b1101: s = sy ? SRC_F2 : SRC_P3;
			4'b1110: s = sy ? SRC_F0 : SRC_P3;
			4'b1111: s = sy ? SRC_F1 : SRC_P2;
			default: s = SRC_F0;
		endcase
		return s;
	endfunction

	function automatic logic [W-1:0] mag_w(input logic [W-1:0] v);
		return v[W-1] ? (~v + W'(1)) : v;
	endfunction

	function automatic logic [W:0] mag_t(input logic [W:0] v);
		return v[W] ? (~v + (W+1)'(1)) : v;
	endfunction

	logic [2:0]  state_q;
	logic        plane_q;
	logic [2:0]  dstep_q;
	logic        term_q;
	logic        psign_q;
	logic [3:0]  tstep_q;
	logic        fail_q;
	logic        outv_q;
	twop_pkg::in_item_t  in_q;
	twop_pkg::out_item_t work_q;
	twop_pkg::out_item_t out_q;
	logic signed [W-1:0] map_q [8];
	logic signed [W-1:0] p_q [4];
	logic signed [2*W:0] acc_q;
	logic [AXW-1:0] eps_q;
	logic [W-1:0]   smag_q;
	logic [W-1:0]   beta_q;
	logic [W-1:0]   alpha_q;
	logic [AXW-1:0] major_q;

	twop_pkg::unit_req_t u_req;
	logic [UW-1:0] u_x;
	logic [UW-1:0] u_y;
	logic          u_done;
	logic [UW-1:0] u_res;

	logic signed [W-1:0] f [4];
	logic signed [W-1:0] m [4];
	logic signed [W-1:0] opx;
	logic signed [W-1:0] opy;
	logic signed [2*W:0] prod;
	logic signed [2*W:0] acc_sh;
	logic signed [W-1:0] dot_val;
	logic signed [W:0]   tr;
	logic signed [W:0]   nd;
	logic [W:0]          tmag;
	logic [W:0]          nmag;
	logic                tr_bad;
	logic                aneg;
	logic [W-1:0]        beta_v;
	logic [W-1:0]        alpha_v;
	logic [AXW-1:0]      axis_v;

	twop_serial u_serial (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (u_req),
		.x      (u_x),
		.y      (u_y),
		.done   (u_done),
		.res    (u_res)
	);

	always_comb begin
		f[0] = plane_q ? in_q.y_m11 : in_q.x_m11;
		f[1] = plane_q ? in_q.y_m12 : in_q.x_m12;
		f[2] = plane_q ? in_q.y_m21 : in_q.x_m21;
		f[3] = plane_q ? in_q.y_m22 : in_q.x_m22;
		m[0] = plane_q ? map_q[4] : map_q[0];
		m[1] = plane_q ? map_q[5] : map_q[1];
		m[2] = plane_q ? map_q[6] : map_q[2];
		m[3] = plane_q ? map_q[7] : map_q[3];
	end

	function automatic logic signed [W-1:0] pick(input logic [3:0] s,
		input logic signed [W-1:0] f0, input logic signed [W-1:0] f1,
		input logic signed [W-1:0] f2, input logic signed [W-1:0] f3,
		input logic signed [W-1:0] g0, input logic signed [W-1:0] g1,
		input logic signed [W-1:0] g2, input logic signed [W-1:0] g3,
		input logic signed [W-1:0] p0, input logic signed [W-1:0] p1,
		input logic signed [W-1:0] p2, input logic signed [W-1:0] p3);
		logic signed [W-1:0] v;
		v = f0;
		case (s)
			SRC_F0:  v = f0;
			SRC_F1:  v = f1;
			SRC_F2:  v = f2;
			SRC_F3:  v = f3;
			SRC_G0:  v = g0;
			SRC_G1:  v = g1;
			SRC_G2:  v = g2;
			SRC_G3:  v = g3;
			SRC_P0:  v = p0;
			SRC_P1:  v = p1;
			SRC_P2:  v = p2;
			SRC_P3:  v = p3;
			default: v = f0;
		endcase
		return v;
	endfunction

	always_comb begin
		opx = pick(dot_src(dstep_q, term_q, 1'b0), f[0], f[1], f[2], f[3],
			m[0], m[1], m[2], m[3], p_q[0], p_q[1], p_q[2], p_q[3]);
		opy = pick(dot_src(dstep_q, term_q, 1'b1), f[0], f[1], f[2], f[3],
			m[0], m[1], m[2], m[3], p_q[0], p_q[1], p_q[2], p_q[3]);
		prod = $signed({1'b0, u_res[2*W-1:0]});
		if (psign_q)
			prod = -prod;
		acc_sh = acc_q >>> F;
		if (acc_sh > ACC_MAX)
			dot_val = W_MAX;
		else if (acc_sh < ACC_MIN)
			dot_val = W_MIN;
		else
			dot_val = acc_sh[W-1:0];

		tr     = $signed({m[0][W-1], m[0]}) + $signed({m[3][W-1], m[3]});
		nd     = $signed({m[0][W-1], m[0]}) - $signed({m[3][W-1], m[3]});
		tmag   = mag_t(tr);
		nmag   = mag_t(nd);
		tr_bad = (tr >= T_LIM) || (tr <= T_NLIM);
		aneg   = nd[W] ^ m[1][W-1];

		beta_v = (u_res > U_WMAX) ? W_MAX : u_res[W-1:0];
		if (aneg)
			alpha_v = (u_res > U_WHALF) ? W_MIN : (~u_res[W-1:0] + W'(1));
		else
			alpha_v = (u_res > U_WMAX) ? W_MAX : u_res[W-1:0];
		axis_v = (u_res > U_AXMAX) ? {AXW{1'b1}} : u_res[AXW-1:0];
	end

	// operands for the serial unit
	always_comb begin
		u_req.start = 1'b0;
		u_req.op    = twop_pkg::OP_MUL;
		u_x         = '0;
		u_y         = '0;
		if (state_q == ST_PM_GO) begin
			u_req.start = 1'b1;
			u_x = UW'(mag_w(opx));
			u_y = UW'(mag_w(opy));
		end else if (state_q == ST_TW_GO) begin
			case (tstep_q)
				4'd0: begin
					u_req.start = !tr_bad;
					u_x = UW'(tmag);
					u_y = UW'(tmag);
				end
				4'd1: begin
					u_req.start = 1'b1;
					u_req.op    = twop_pkg::OP_SQRT;
					u_x = (U_FOUR - u_res) >> 2;
				end
				4'd2: begin
					u_req.start = smag_q != '0;
					u_req.op    = twop_pkg::OP_DIV;
					u_x = UW'(mag_w(m[1])) << F;
					u_y = UW'(smag_q);
				end
				4'd3: begin
					u_req.start = beta_q != '0;
					u_req.op    = twop_pkg::OP_DIV;
					u_x = UW'(nmag) << F;
					u_y = UW'(smag_q) << 1;
				end
				4'd4: begin
					u_req.start = 1'b1;
					u_x = UW'(beta_q);
					u_y = UW'(eps_q);
				end
				4'd5, 4'd9: begin
					u_req.start = 1'b1;
					u_req.op    = twop_pkg::OP_SQRT;
					u_x = u_res;
				end
				4'd6: begin
					u_req.start = 1'b1;
					u_x = UW'(mag_w(alpha_q));
					u_y = UW'(mag_w(alpha_q));
				end
				4'd7: begin
					u_req.start = 1'b1;
					u_x = U_ONE2 + u_res;
					u_y = UW'(eps_q);
				end
				4'd8: begin
					u_req.start = 1'b1;
					u_req.op    = twop_pkg::OP_DIV;
					u_x = u_res;
					u_y = UW'(beta_q);
				end
				default: u_req.start = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			plane_q <= 1'b0;
			dstep_q <= '0;
			term_q  <= 1'b0;
			tstep_q <= '0;
			fail_q  <= 1'b0;
			outv_q  <= 1'b0;
			eps_q   <= AXW'(1) << F;
			for (int i = 0; i < 8; i++)
				map_q[i] <= (i == 0 || i == 3 || i == 4 || i == 7) ? W'(1) << F : '0;
		end else begin
			if (cfg_we)
				eps_q <= cfg_wdata;
			if (outv_q && out_ready)
				outv_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						plane_q <= 1'b0;
						dstep_q <= '0;
						term_q  <= 1'b0;
						tstep_q <= '0;
						if (in_data.opcode) begin
							state_q <= ST_PM_GO;
						end else begin
							map_q[0] <= in_data.x_m11;
							map_q[1] <= in_data.x_m12;
							map_q[2] <= in_data.x_m21;
							map_q[3] <= in_data.x_m22;
							map_q[4] <= in_data.y_m11;
							map_q[5] <= in_data.y_m12;
							map_q[6] <= in_data.y_m21;
							map_q[7] <= in_data.y_m22;
							state_q  <= ST_TW_GO;
						end
					end
				end
				ST_PM_GO: state_q <= ST_PM_WT;
				ST_PM_WT: begin
					if (u_done) begin
						term_q  <= 1'b1;
						state_q <= term_q ? ST_PM_WR : ST_PM_GO;
					end
				end
				ST_PM_WR: begin
					if (dstep_q[2])
						map_q[{plane_q, dstep_q[1:0]}] <= dot_val;
					term_q  <= 1'b0;
					dstep_q <= dstep_q + 3'd1;
					if (dstep_q == 3'd7) begin
						plane_q <= !plane_q;
						state_q <= plane_q ? ST_TW_GO : ST_PM_GO;
					end else begin
						state_q <= ST_PM_GO;
					end
				end
				ST_TW_GO: begin
					if (u_req.start) begin
						state_q <= ST_TW_WT;
					end else begin
						fail_q  <= 1'b1;
						state_q <= ST_TW_WR;
					end
				end
				ST_TW_WT: begin
					if (u_done) begin
						tstep_q <= tstep_q + 4'd1;
						if (tstep_q == 4'd9) begin
							fail_q  <= 1'b0;
							state_q <= ST_TW_WR;
						end else begin
							state_q <= ST_TW_GO;
						end
					end
				end
				ST_TW_WR: begin
					tstep_q <= '0;
					fail_q  <= 1'b0;
					plane_q <= !plane_q;
					state_q <= plane_q ? ST_DONE : ST_TW_GO;
				end
				ST_DONE: begin
					if (!outv_q || out_ready) begin
						outv_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid)
			in_q <= in_data;
		if (state_q == ST_PM_GO)
			psign_q <= opx[W-1] ^ opy[W-1] ^ (dstep_q[2] & term_q);
		if (state_q == ST_PM_WT && u_done)
			acc_q <= term_q ? acc_q + prod : prod;
		if (state_q == ST_PM_WR && !dstep_q[2])
			p_q[dstep_q[1:0]] <= dot_val;
		if (state_q == ST_TW_WT && u_done) begin
			case (tstep_q)
				4'd1:    smag_q  <= u_res[W-1:0];
				4'd2:    beta_q  <= beta_v;
				4'd3:    alpha_q <= alpha_v;
				4'd5:    major_q <= axis_v;
				4'd9: begin
					if (plane_q) begin
						work_q.alpha_y      <= alpha_q;
						work_q.beta_y       <= beta_q;
						work_q.y_axis_major <= major_q;
						work_q.y_axis_minor <= axis_v;
					end else begin
						work_q.alpha_x      <= alpha_q;
						work_q.beta_x       <= beta_q;
						work_q.x_axis_major <= major_q;
						work_q.x_axis_minor <= axis_v;
					end
				end
				default: smag_q <= smag_q;
			endcase
		end
		if (state_q == ST_TW_WR) begin
			if (plane_q) begin
				work_q.y_unstable <= fail_q;
				if (fail_q) begin
					work_q.alpha_y      <= '0;
					work_q.beta_y       <= '0;
					work_q.y_axis_major <= '0;
					work_q.y_axis_minor <= '0;
				end
			end else begin
				work_q.x_unstable <= fail_q;
				if (fail_q) begin
					work_q.alpha_x      <= '0;
					work_q.beta_x       <= '0;
					work_q.x_axis_major <= '0;
					work_q.x_axis_minor <= '0;
				end
			end
		end
		if (state_q == ST_DONE && (!outv_q || out_ready))
			out_q <= work_q;
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = outv_q;
	assign out_data  = out_q;
endmodule
`default_nettype wire

[test/twiss_optics_propagator_test.sv]
`timescale 1ns / 1ps
module twiss_optics_propagator_test;

	localparam int WATCHDOG_LIMIT = 50000;
	localparam int AXB = twop_pkg::AXIS_BITS;
	localparam int FRB = twop_pkg::FRAC_BITS;
	localparam logic OPC_LOAD = 1'b0;
	localparam logic OPC_PROP = 1'b1;
	localparam logic [AXB-1:0] EMIT_ONE = 31'h0100_0000;
	localparam logic [AXB-1:0] AXIS_MAX = 31'h7fff_ffff;
	localparam logic signed [31:0] ONE = 32'sh0100_0000;
	localparam logic signed [127:0] TRACE_LIM = 128'sd1 << (FRB + 1);

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	twop_pkg::in_item_t in_data;
	logic out_valid;
	logic out_ready;
	twop_pkg::out_item_t out_data;
	logic cfg_we;
	logic [AXB-1:0] cfg_wdata;

	twiss_optics_propagator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// predictor state: one-turn map x11,x12,x21,x22,y11,y12,y21,y22
	logic signed [31:0] turn_map [8];
	logic [AXB-1:0] emit_model;
	twop_pkg::out_item_t twiss_expected [$];

	int send_idle_pct;
	int recv_idle_pct;
	int hold_cnt;
	int errors;
	int n_sent;
	int n_recv;
	int n_unstable;
	int idle_cnt;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic logic signed [31:0] sat_word(input logic signed [127:0] x);
		if (x > 128'sh7fff_ffff)
			return 32'sh7fff_ffff;
		if (x < -128'sh8000_0000)
			return 32'sh8000_0000;
		return x[31:0];
	endfunction

	function automatic logic [AXB-1:0] sat_axis(input logic [127:0] x);
		return (x > AXIS_MAX) ? AXIS_MAX : x[AXB-1:0];
	endfunction

	function automatic logic [127:0] isqrt128(input logic [127:0] n);
		logic [127:0] res;
		logic [127:0] b;
		res = 0;
		b = 128'd1 << 126;
		while (b > n && b != 0)
			b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// (a*b +/- c*d) >> frac, floor, saturated
	function automatic logic signed [31:0] dot2(input logic signed [31:0] a, b, c, d,
			input logic sub);
		logic signed [127:0] p;
		logic signed [127:0] q;
		logic signed [127:0] wa, wb, wc, wd;
		wa = a; wb = b; wc = c; wd = d;
		p = wa * wb;
		q = wc * wd;
		p = sub ? p - q : p + q;
		return sat_word(p >>> FRB);
	endfunction

	task automatic twiss_plane(input logic signed [31:0] m11, m12, m22,
			output logic signed [31:0] alpha, beta,
			output logic [AXB-1:0] major, minor, output logic unstable);
		logic signed [127:0] tr, dif, q;
		logic [127:0] tmag, smag, mag, bu, amag, rad;
		logic aneg;
		alpha = 0; beta = 0; major = 0; minor = 0; unstable = 1'b1;
		tr = m11;
		tr = tr + m22;
		if (tr >= TRACE_LIM || tr <= -TRACE_LIM)
			return;
		tmag = (tr < 0) ? -tr : tr;
		smag = isqrt128(((128'd1 << (2 * FRB + 2)) - tmag * tmag) >> 2);
		if (smag == 0)
			return;
		q = m12;
		mag = (q < 0) ? -q : q;
		bu = (mag << FRB) / smag;
		beta = (bu > 128'h7fff_ffff) ? 32'sh7fff_ffff : bu[31:0];
		if (beta == 0)
			return;
		dif = m11;
		dif = dif - m22;
		aneg = (dif < 0) ^ (m12 < 0);
		mag = (dif < 0) ? -dif : dif;
		q = (mag << FRB) / (smag << 1);
		if (aneg)
			q = -q;
		alpha = sat_word(q);
		bu = {96'd0, beta};
		major = sat_axis(isqrt128(bu * emit_model));
		q = alpha;
		amag = (q < 0) ? -q : q;
		rad = (((128'd1 << (2 * FRB)) + amag * amag) * emit_model) / bu;
		minor = sat_axis(isqrt128(rad));
		unstable = 1'b0;
	endtask

	task automatic propagate_and_twiss(input twop_pkg::in_item_t it,
			output twop_pkg::out_item_t r);
		logic signed [31:0] f [8];
		logic signed [31:0] p11, p12, p21, p22, a, b, c, d;
		f = '{it.x_m11, it.x_m12, it.x_m21, it.x_m22,
			it.y_m11, it.y_m12, it.y_m21, it.y_m22};
		if (it.opcode == OPC_LOAD) begin
			turn_map = f;
		end else begin
			for (int k = 0; k < 8; k += 4) begin
				a = f[k]; b = f[k+1]; c = f[k+2]; d = f[k+3];
				p11 = dot2(a, turn_map[k], b, turn_map[k+2], 1'b0);
				p12 = dot2(a, turn_map[k+1], b, turn_map[k+3], 1'b0);
				p21 = dot2(c, turn_map[k], d, turn_map[k+2], 1'b0);
				p22 = dot2(c, turn_map[k+1], d, turn_map[k+3], 1'b0);
				turn_map[k]   = dot2(p11, d, p12, c, 1'b1);
				turn_map[k+1] = dot2(p12, a, p11, b, 1'b1);
				turn_map[k+2] = dot2(p21, d, p22, c, 1'b1);
				turn_map[k+3] = dot2(p22, a, p21, b, 1'b1);
			end
		end
		twiss_plane(turn_map[0], turn_map[1], turn_map[3], r.alpha_x, r.beta_x,
			r.x_axis_major, r.x_axis_minor, r.x_unstable);
		twiss_plane(turn_map[4], turn_map[5], turn_map[7], r.alpha_y, r.beta_y,
			r.y_axis_major, r.y_axis_minor, r.y_unstable);
	endtask

	task automatic send_request(input twop_pkg::in_item_t it);
		twop_pkg::out_item_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do
			@(posedge clk);
		while (!in_ready);
		propagate_and_twiss(it, r);
		twiss_expected.push_back(r);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (twiss_expected.size() != 0)
			@(posedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_emittance(input logic [AXB-1:0] v);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		emit_model = v;
	endtask

	function automatic logic signed [31:0] rand_span(input int unsigned span);
		return $signed($urandom_range(2 * span)) - $signed(span);
	endfunction

	function automatic twop_pkg::in_item_t make_request(input logic opc,
			input logic signed [31:0] x11, x12, x21, x22, y11, y12, y21, y22);
		twop_pkg::in_item_t it;
		it.opcode = opc;
		it.x_m11 = x11; it.x_m12 = x12; it.x_m21 = x21; it.x_m22 = x22;
		it.y_m11 = y11; it.y_m12 = y12; it.y_m21 = y21; it.y_m22 = y22;
		return it;
	endfunction

	// stable cell map: |trace| < 2 and nonzero m12
	function automatic twop_pkg::in_item_t rand_stable_load();
		logic signed [31:0] m [8];
		for (int k = 0; k < 8; k += 4) begin
			m[k] = rand_span(16_600_000);
			m[k+3] = rand_span(16_600_000);
			m[k+1] = rand_span(335_544_320);
			if (m[k+1] == 0)
				m[k+1] = ONE;
			m[k+2] = rand_span(33_554_432);
		end
		return make_request(OPC_LOAD, m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7]);
	endfunction

	// drift or thin lens per plane, unit determinant
	function automatic twop_pkg::in_item_t rand_element();
		logic signed [31:0] m [8];
		for (int k = 0; k < 8; k += 4) begin
			m[k] = ONE;
			m[k+3] = ONE;
			if ($urandom_range(1)) begin
				m[k+1] = $signed($urandom_range(67_108_864));
				m[k+2] = 0;
			end else begin
				m[k+1] = 0;
				m[k+2] = rand_span(33_554_432);
			end
		end
		return make_request(OPC_PROP, m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7]);
	endfunction

	function automatic twop_pkg::in_item_t rand_noise();
		twop_pkg::in_item_t it;
		it.opcode = 1'($urandom_range(1));
		it.x_m11 = $urandom; it.x_m12 = $urandom; it.x_m21 = $urandom; it.x_m22 = $urandom;
		it.y_m11 = $urandom; it.y_m12 = $urandom; it.y_m21 = $urandom; it.y_m22 = $urandom;
		return it;
	endfunction

	task automatic test_directed();
		logic signed [31:0] mx, mn;
		mx = 32'sh7fff_ffff;
		mn = 32'sh8000_0000;
		// identity element; right after reset the map is identity: trace exactly two
		send_request(make_request(OPC_PROP, ONE, 0, 0, ONE, ONE, 0, 0, ONE));
		send_request(make_request(OPC_LOAD, 0, ONE, -ONE, 0, 0, -ONE, ONE, 0));
		send_request(make_request(OPC_PROP, ONE, ONE, 0, ONE, ONE, 0, -ONE, ONE));
		send_request(make_request(OPC_LOAD, -ONE, 0, 0, -ONE, -ONE, ONE, 0, -ONE));
		send_request(make_request(OPC_LOAD, mx, mx, mx, mx, mx, mx, mx, mx));
		send_request(make_request(OPC_LOAD, mn, mn, mn, mn, mn, mn, mn, mn));
		send_request(make_request(OPC_LOAD, 0, 0, 0, 0, 0, 0, 0, 0));
		// trace inside the limit: zero m12 in y, negative m12 in x
		send_request(make_request(OPC_LOAD, ONE / 2, -ONE, ONE / 4, 0, ONE / 2, 0, ONE, 0));
		// sine tiny: beta saturates
		send_request(make_request(OPC_LOAD, ONE - 1, mx, 0, ONE - 2, 16_777_000, mx,
			0, -16_777_000));
		send_request(make_request(OPC_LOAD, ONE - 1, mn, 0, ONE - 1, 0, 1, 0, 0));
		// products saturate
		send_request(make_request(OPC_LOAD, ONE / 2, ONE, -ONE, 0, 0, ONE, -ONE, 0));
		send_request(make_request(OPC_PROP, mx, mx, mx, mx, mn, mn, mn, mn));
		send_request(make_request(OPC_LOAD, 0, ONE, -ONE, 0, ONE / 3, 2 * ONE, -ONE / 3, 0));
		// element map with determinant not one
		send_request(make_request(OPC_PROP, 2 * ONE, ONE, ONE, 2 * ONE, ONE / 2, 0, 0,
			ONE / 2));
		send_request(make_request(OPC_PROP, mn, 0, 0, mx, 1, -1, 1, -1));
	endtask

	task automatic test_random(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 25)
				send_request(rand_noise());
			else if ($urandom_range(99) < 40)
				send_request(rand_stable_load());
			else
				send_request(rand_element());
		end
	endtask

	task automatic test_output_backpressure();
		wait_drained();
		@(posedge clk);
		hold_cnt = 4000;
		@(negedge clk);
		for (int i = 0; i < 6; i++)
			send_request(i == 0 ? rand_stable_load() : rand_element());
	endtask

	task automatic test_drain_pause();
		for (int i = 0; i < 5; i++)
			send_request(rand_element());
		wait_drained();
		test_random(20);
	endtask

	// receiver: random stalls plus an optional long hold-off
	always @(negedge clk) begin
		if (hold_cnt > 0) begin
			hold_cnt <= hold_cnt - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic check_field(input string name, input logic [31:0] e, a);
		if (e !== a) begin
			$error("%s mismatch: expected %h, actual %h", name, e, a);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		twop_pkg::out_item_t e;
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cnt <= 0;
			else
				idle_cnt <= idle_cnt + 1;
			if (out_valid && out_ready) begin
				if (twiss_expected.size() == 0) begin
					$error("result with no request outstanding");
					errors++;
				end else begin
					e = twiss_expected.pop_front();
					n_recv++;
					if (e.x_unstable || e.y_unstable)
						n_unstable++;
					check_field("alpha_x", e.alpha_x, out_data.alpha_x);
					check_field("beta_x", e.beta_x, out_data.beta_x);
					check_field("alpha_y", e.alpha_y, out_data.alpha_y);
					check_field("beta_y", e.beta_y, out_data.beta_y);
					check_field("x_axis_major", 32'(e.x_axis_major),
						32'(out_data.x_axis_major));
					check_field("x_axis_minor", 32'(e.x_axis_minor),
						32'(out_data.x_axis_minor));
					check_field("y_axis_major", 32'(e.y_axis_major),
						32'(out_data.y_axis_major));
					check_field("y_axis_minor", 32'(e.y_axis_minor),
						32'(out_data.y_axis_minor));
					check_field("x_unstable", 32'(e.x_unstable), 32'(out_data.x_unstable));
					check_field("y_unstable", 32'(e.y_unstable), 32'(out_data.y_unstable));
				end
			end
			if (idle_cnt >= WATCHDOG_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		hold_cnt = 0;
		errors = 0;
		n_sent = 0;
		n_recv = 0;
		n_unstable = 0;
		idle_cnt = 0;
		send_idle_pct = 6;
		recv_idle_pct = 88;
		turn_map = '{ONE, 0, 0, ONE, ONE, 0, 0, ONE};
		emit_model = EMIT_ONE;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		write_emittance(AXIS_MAX);
		test_directed();
		test_random(300);

		send_idle_pct = 88;
		recv_idle_pct = 6;
		write_emittance('0);
		test_random(250);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_emittance(AXB'($urandom_range(1, 32'h7fff_fffe)));
		test_random(250);
		test_output_backpressure();
		test_drain_pause();
		write_emittance(EMIT_ONE);
		test_random(120);

		wait_drained();
		$display("covered %0d requests (%0d results, %0d with an unstable plane)",
			n_sent, n_recv, n_unstable);
		$display("emittance settings: 1.0, max, zero, random; stalls on both sides");
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
